// ===== sv/dpt_pkg.sv =====
package dpt_pkg;

  // input item kinds
  typedef enum logic [1:0] {
    KIND_TEMP  = 2'd0,
    KIND_HUM   = 2'd1,
    KIND_TICK  = 2'd2
  } kind_e;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_TEMP_GAIN = 2'd0,
    CFG_HUM_GAIN  = 2'd1
  } cfg_idx_e;

  // back end sequencer states
  typedef enum logic [2:0] {
    B_IDLE,
    B_NORM,
    B_SQR,
    B_LN,
    B_DIV1,
    B_G,
    B_DIV2,
    B_OUT
  } back_state_e;

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned DVW    = 34;
  localparam longint      SAT32  = 64'sd2147483647;
  localparam longint      LN2_Q26 = 64'sd46516320;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [15:0] raw_value;
  } in_item_t;

  typedef struct packed {
    logic signed [10:0] dewpoint_tenths;
    logic               invalid;
  } out_item_t;

  // latched readings taken by a tick
  typedef struct packed {
    logic signed [31:0] temperature_c;
    logic signed [31:0] humidity_pct;
  } snap_t;

endpackage

// ===== sv/dpt_front.sv =====
module dpt_front #(
  parameter int FRAC_BITS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  dpt_pkg::in_item_t in_item_i,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [1:0]       cfg_index_i,
  input  logic [31:0]      cfg_data_i,
  input  logic             full_i,
  output logic             push_o,
  output dpt_pkg::snap_t   push_data_o
);
  import dpt_pkg::*;

  logic [31:0]        temp_gain_q, hum_gain_q;
  logic signed [31:0] temperature_q, temperature_d;
  logic signed [31:0] humidity_q, humidity_d;
  logic               accept;
  logic [31:0]        gain_sel;
  logic signed [48:0] prod_c;
  logic signed [31:0] sat_c;

  assign in_ready_o  = !full_i;
  assign cfg_ready_o = 1'b1;
  assign accept      = in_valid_i && in_ready_o;

  // scale the reading by its gain and saturate to 32 bits
  assign gain_sel = (in_item_i.kind == KIND_TEMP) ? temp_gain_q : hum_gain_q;
  assign prod_c   = 49'(in_item_i.raw_value) * $signed({17'b0, gain_sel});

  always_comb begin
    if (prod_c > 49'(SAT32)) begin
      sat_c = 32'(SAT32);
    end else if (prod_c < -49'(SAT32) - 49'sd1) begin
      sat_c = -32'(SAT32) - 32'sd1;
    end else begin
      sat_c = 32'(prod_c);
    end
  end

  // latch update
  always_comb begin
    temperature_d = temperature_q;
    humidity_d    = humidity_q;
    if (accept && in_item_i.kind == KIND_TEMP) begin
      temperature_d = sat_c;
    end
    if (accept && in_item_i.kind == KIND_HUM) begin
      humidity_d = sat_c;
    end
  end

  // a tick hands a snapshot to the queue
  assign push_o = accept && (in_item_i.kind == KIND_TICK);
  assign push_data_o.temperature_c = temperature_q;
  assign push_data_o.humidity_pct  = humidity_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_gain_q   <= 32'(longint'(1) <<< FRAC_BITS);
      hum_gain_q    <= 32'(longint'(1) <<< FRAC_BITS);
      temperature_q <= '0;
      humidity_q    <= '0;
    end else begin
      temperature_q <= temperature_d;
      humidity_q    <= humidity_d;
      if (cfg_valid_i && cfg_index_i == CFG_TEMP_GAIN) begin
        temp_gain_q <= cfg_data_i;
      end
      if (cfg_valid_i && cfg_index_i == CFG_HUM_GAIN) begin
        hum_gain_q <= cfg_data_i;
      end
    end
  end

endmodule

// ===== sv/dpt_fifo.sv =====
module dpt_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  dpt_pkg::snap_t push_data_i,
  input  logic           pop_i,
  output dpt_pkg::snap_t pop_data_o,
  output logic           full_o,
  output logic           empty_o
);
  import dpt_pkg::*;

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

  snap_t           mem_q [QDEPTH];
  logic [PW-1:0]   wr_q, rd_q;
  logic [PW:0]     cnt_q;

  assign full_o     = (cnt_q == (PW+1)'(QDEPTH));
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = mem_q[rd_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PW'(QDEPTH - 1)) ? '0 : wr_q + PW'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == PW'(QDEPTH - 1)) ? '0 : rd_q + PW'(1);
      end
      cnt_q <= cnt_q + (PW+1)'(push_i) - (PW+1)'(pop_i);
    end
  end

endmodule

// ===== sv/dpt_div.sv =====
module dpt_div #(
  parameter int NW = 56
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [NW:0]      num_i,
  input  logic signed [dpt_pkg::DVW:0] den_i,
  output logic                    done_o,
  output logic signed [NW:0]      quot_o
);
  import dpt_pkg::*;

  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0]  nq_q;
  logic [DVW-1:0] rem_q, den_q;
  logic           neg_q, busy_q, done_q;
  logic [CW-1:0]  cnt_q;
  logic [NW:0]    num_abs;
  logic [DVW:0]   den_abs;
  logic [DVW:0]   rem_sh;
  logic           fit;

  assign num_abs = num_i[NW] ? (NW+1)'(0) - num_i : num_i;
  assign den_abs = den_i[DVW] ? (DVW+1)'(0) - den_i : den_i;

  // one restoring step per cycle
  assign rem_sh = {rem_q, nq_q[NW-1]};
  assign fit    = rem_sh >= {1'b0, den_q};

  assign done_o = done_q;
  assign quot_o = neg_q ? (NW+1)'(0) - $signed({1'b0, nq_q}) : $signed({1'b0, nq_q});

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      nq_q  <= num_abs[NW-1:0];
      den_q <= den_abs[DVW-1:0];
      rem_q <= '0;
      neg_q <= num_i[NW] ^ den_i[DVW];
    end else if (busy_q) begin
      rem_q <= fit ? DVW'(rem_sh - {1'b0, den_q}) : rem_sh[DVW-1:0];
      nq_q  <= {nq_q[NW-2:0], fit};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(NW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== sv/dpt_back.sv =====
module dpt_back #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               empty_i,
  input  dpt_pkg::snap_t     pop_data_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output dpt_pkg::out_item_t out_item_o
);
  import dpt_pkg::*;

  function automatic longint log2_q30_const(longint unsigned v);
    longint unsigned m;
    longint          y;
    int              e;
    e = 0;
    for (int i = 0; i < 31; i++) begin
      if (e < 31 && (v >> (e + 1)) != 0) e = e + 1;
    end
    m = v << (30 - e);
    y = 0;
    for (int i = 0; i < 30; i++) begin
      m = (m * m) >> 30;
      if (m >= (64'd1 << 31)) begin
        m = m >> 1;
        y = y + (longint'(1) <<< (29 - i));
      end
    end
    return (longint'(e) <<< 30) + y;
  endfunction

  localparam int     NW      = FRAC_BITS + 40;
  localparam int     TW      = FRAC_BITS + 13;
  localparam int     LnShift = 56 - FRAC_BITS;
  localparam longint MagA    = longint'(141) <<< (FRAC_BITS - 3);
  localparam longint MagB    = ((longint'(24304) <<< FRAC_BITS) + 50) / 100;
  localparam longint TdLim   = longint'(100) <<< FRAC_BITS;
  localparam longint Log100  = log2_q30_const(64'd100 << FRAC_BITS);
  localparam longint Bias    = (longint'(1) <<< FRAC_BITS) - 1;

  back_state_e state_q, state_d;

  logic signed [31:0]  t_q, g_q, g_c, q_c, ln_c;
  logic signed [DVW:0] d1_q, d1_c, d2_c;
  logic [30:0]         m_q;
  logic [4:0]          sh_q, cnt_q, step_k;
  logic [29:0]         y_q;
  logic signed [63:0]  prod_q;
  logic                res_inv_q;
  logic signed [10:0]  res_tenths_q, tenths_c;
  logic                out_valid_q;
  out_item_t           out_item_q;
  logic                bad_c, top_zero, out_free;
  logic [61:0]         sq_c;
  logic [34:0]         logv_c;
  logic signed [36:0]  ln_diff;
  logic signed [32:0]  sum_c;
  logic signed [NW:0]  num1_c, num2_c, div_num, div_quot;
  logic signed [DVW:0] div_den;
  logic                div_start, div_done;
  logic signed [FRAC_BITS+8:0] td_c;
  logic signed [TW-1:0] x10_c, adj_c;

  dpt_div #(.NW(NW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // validity check at pop
  assign d1_c  = (DVW+1)'(MagB) + (DVW+1)'(pop_data_i.temperature_c);
  assign bad_c = (pop_data_i.humidity_pct <= 32'sd0) || (d1_c == '0);

  // normalize: binary search for the leading one
  assign step_k   = 5'd16 >> cnt_q[2:0];
  assign top_zero = (m_q >> (5'd31 - step_k)) == 31'd0;

  // log2 squaring step
  assign sq_c    = 62'(m_q) * 62'(m_q);
  assign logv_c  = {5'd30 - sh_q, y_q};
  assign ln_diff = $signed({2'b00, logv_c}) - 37'(Log100);
  assign ln_c    = 32'(prod_q >>> LnShift);

  // a*t/(b+t) and g, both clamped
  assign num1_c = (NW+1)'(MagA) * (NW+1)'(t_q);
  always_comb begin
    if (div_quot > (NW+1)'(SAT32)) begin
      q_c = 32'(SAT32);
    end else if (div_quot < -(NW+1)'(SAT32)) begin
      q_c = -32'(SAT32);
    end else begin
      q_c = 32'(div_quot);
    end
    sum_c = 33'(ln_c) + 33'(q_c);
    if (sum_c > 33'(SAT32)) begin
      g_c = 32'(SAT32);
    end else if (sum_c < -33'(SAT32)) begin
      g_c = -32'(SAT32);
    end else begin
      g_c = 32'(sum_c);
    end
  end

  // b*g/(a-g), clamp, tenths truncated toward zero
  assign d2_c   = (DVW+1)'(MagA) - (DVW+1)'(g_q);
  assign num2_c = (NW+1)'(MagB) * (NW+1)'(g_q);
  always_comb begin
    if (div_quot > (NW+1)'(TdLim)) begin
      td_c = (FRAC_BITS+9)'(TdLim);
    end else if (div_quot < -(NW+1)'(TdLim)) begin
      td_c = -(FRAC_BITS+9)'(TdLim);
    end else begin
      td_c = (FRAC_BITS+9)'(div_quot);
    end
    x10_c    = TW'(td_c) * TW'(10);
    adj_c    = x10_c[TW-1] ? x10_c + TW'(Bias) : x10_c;
    tenths_c = 11'(adj_c >>> FRAC_BITS);
  end

  assign out_free = !out_valid_q || out_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      B_IDLE: begin
        if (!empty_i) state_d = bad_c ? B_OUT : B_NORM;
      end
      B_NORM: begin
        if (cnt_q == 5'd4) state_d = B_SQR;
      end
      B_SQR: begin
        if (cnt_q == 5'd29) state_d = B_LN;
      end
      B_LN:   state_d = B_DIV1;
      B_DIV1: begin
        if (div_done) state_d = B_G;
      end
      B_G:    state_d = (d2_c == '0) ? B_OUT : B_DIV2;
      B_DIV2: begin
        if (div_done) state_d = B_OUT;
      end
      B_OUT: begin
        if (out_free) state_d = B_IDLE;
      end
      default: state_d = B_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    pop_o     = 1'b0;
    div_start = 1'b0;
    div_num   = num1_c;
    div_den   = d1_q;
    case (state_q)
      B_IDLE: pop_o = !empty_i;
      B_LN:   div_start = 1'b1;
      B_G: begin
        div_num   = num2_c;
        div_den   = d2_c;
        div_start = (d2_c != '0);
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      B_IDLE: begin
        t_q          <= pop_data_i.temperature_c;
        d1_q         <= d1_c;
        m_q          <= pop_data_i.humidity_pct[30:0];
        sh_q         <= '0;
        y_q          <= '0;
        res_inv_q    <= 1'b1;
        res_tenths_q <= '0;
      end
      B_NORM: begin
        if (top_zero) begin
          m_q  <= m_q << step_k;
          sh_q <= sh_q + step_k;
        end
      end
      B_SQR: begin
        if (sq_c[61]) begin
          m_q <= sq_c[61:31];
          y_q <= y_q | (30'd1 << (5'd29 - cnt_q));
        end else begin
          m_q <= sq_c[60:30];
        end
      end
      B_LN:   prod_q <= 64'(ln_diff) * 64'(LN2_Q26);
      B_DIV1: begin
        if (div_done) g_q <= g_c;
      end
      B_DIV2: begin
        if (div_done) begin
          res_inv_q    <= 1'b0;
          res_tenths_q <= tenths_c;
        end
      end
      default: begin
        t_q <= t_q;
      end
    endcase
    if (state_q == B_OUT && out_free) begin
      out_item_q.dewpoint_tenths <= res_tenths_q;
      out_item_q.invalid         <= res_inv_q;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == B_NORM || state_q == B_SQR) begin
        cnt_q <= (state_d != state_q) ? 5'd0 : cnt_q + 5'd1;
      end else begin
        cnt_q <= '0;
      end
      if (state_q == B_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

`ifndef SYNTHESIS
  // an invalid result carries a zero dew point
  a_inv_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.invalid |-> out_item_o.dewpoint_tenths == 11'sd0)
    else $error("invalid result with nonzero dew point");

  // result stays inside the saturation range
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.dewpoint_tenths <= 11'sd1000) &&
                    (out_item_o.dewpoint_tenths >= -11'sd1000))
    else $error("dew point out of range");

  // a finished result reaches the output register
  a_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_OUT) && out_free |=> out_valid_o && (state_q == B_IDLE))
    else $error("result not loaded");

  // pops only from a filled queue
  a_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> !empty_i)
    else $error("pop from empty queue");
`endif

endmodule

// ===== sv/dewpoint_from_temp_humidity_top.sv =====
// Dew-point calculator fed by temperature and humidity readings.
// Input channel (in_valid_i/in_ready_o, in_item_i): kind 0 latches a raw
// temperature times temp_gain, kind 1 a raw humidity times humidity_gain,
// kind 2 is a tick that produces one result item; kind 3 is dropped.
// Readings are latched in registers and produce nothing. A tick snapshots the
// latched values into a two-entry queue; the back end then computes the
// Magnus dew point in tenths of a degree.
// A tick passes through a pop, 5 normalize steps, 30 squarings for log2,
// then two divisions in a shared one-bit-per-cycle divider of
// FRAC_BITS+40 steps each. The back end pops a new tick only after its last
// result is in the output register; readings flow each cycle while the queue
// has room.
// Output channel (out_valid_o/out_ready_i, out_item_o) is registered; when
// the receiver stalls, the back end holds its next result and the queue
// fills, after which in_ready_o drops.
// Config channel (cfg_valid_i/cfg_ready_o) is always ready; index 0 is
// temp_gain, 1 humidity_gain, others ignored. Write only when idle.
// Reset restores both gains to 1.0, clears the readings and empties the
// queue and output.
module dewpoint_from_temp_humidity_top #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  dpt_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output dpt_pkg::out_item_t out_item_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i
);
  import dpt_pkg::*;

  logic  push, pop, full, empty;
  snap_t push_data, pop_data;

  // front end: latches and tick classification
  dpt_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .full_i      (full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  // tick queue
  dpt_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .full_o      (full),
    .empty_o     (empty)
  );

  // back end: dew-point sequencer
  dpt_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .pop_data_i  (pop_data),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule
